FILE: rtl/clrs_pkg.sv
// Package for the character display refresh sequencer.
// Holds command codes, display and CSR constants, the emission record and digit_code.
// No dependencies.
package clrs_pkg;

   typedef enum logic [1:0] {
      CMD_TICK        = 2'd0,
      CMD_WRITE_RAW   = 2'd1,
      CMD_WRITE_DIGIT = 2'd2,
      CMD_SET_CURSOR  = 2'd3
   } cmd_type;

   localparam logic [7:0] BLANK_CODE = 8'h20;
   localparam logic [7:0] DIGIT_BASE = 8'h30;
   localparam logic [7:0] ROW0_ADDR  = 8'h80;
   localparam logic [7:0] ROW1_ADDR  = 8'hC0;
   localparam logic [7:0] WAIT_RESET = 8'd25;
   localparam logic [7:0] DIGIT_MAX  = 8'd9;

   localparam int         CSR_ADDR_W     = 3;
   localparam logic [2:0] CSR_WAIT_TICKS = 3'd0;

   typedef struct packed {
      logic       emit;
      logic       register_select;
      logic       from_mem;
      logic [7:0] data_byte;
   } emit_type;

   function automatic logic [7:0] digit_code(input logic [7:0] value);
      logic [7:0] code;
      if (value <= DIGIT_MAX) begin
         code = DIGIT_BASE + value;
      end else begin
         code = BLANK_CODE;
      end
      return code;
   endfunction

endpackage

FILE: rtl/clrs_if.sv
// Request and response channel interfaces of the refresh sequencer.
// Valid/ready handshake; no dependencies.
interface clrs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [4:0] cell_index;
   logic [7:0] char_value;
   logic [4:0] cursor_position;

   modport source (output valid, command, cell_index, char_value, cursor_position,
                   input ready);
   modport sink   (input valid, command, cell_index, char_value, cursor_position,
                   output ready);
endinterface

interface clrs_rsp_if;
   logic       valid;
   logic       ready;
   logic       register_select;
   logic [7:0] data_byte;

   modport source (output valid, register_select, data_byte, input ready);
   modport sink   (input valid, register_select, data_byte, output ready);
endinterface

FILE: rtl/char_lcd_refresh_sequencer.sv
// Top level of the two-row character display refresh sequencer.
// Depends on clrs_pkg, clrs_if, clrs_seq and clrs_buf.
//
// Usage:
//   req_if carries one request per handshake: a tick, a raw or digit write
//   into a buffer cell, or a cursor update. Only a tick outside the wait
//   phase yields a response on rsp_if: a register-select bit and a byte for
//   the display controller (row address, character, or cursor address).
//   A response is valid in the cycle after its tick is accepted.
//   Throughput: one request per cycle unless stalled; the buffer RAM is read
//   once per character tick, written once per in-range write, one port each.
//   The output register frees itself when rsp_if.ready is high, so requests
//   flow back to back. When the receiver stalls, the response holds and
//   req_if.ready drops until it is taken.
//   Reset: cells read as blank through per-cell written flags, so no
//   clearing pass is needed; the first response is the top row address.
//   The wait between frames is set by the wait_ticks register at byte
//   address 0 of the APB port (reset value 25).
module char_lcd_refresh_sequencer import clrs_pkg::*; #(
   parameter int ROW_LENGTH = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   clrs_req_if.sink              req_if,
   clrs_rsp_if.source            rsp_if,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   localparam int CELL_COUNT = 2 * ROW_LENGTH;
   localparam int ADDR_W     = $clog2(CELL_COUNT);

   logic              accept;
   emit_type          emit;
   emit_type          out_ff;
   logic              out_valid_ff;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [7:0]        wr_data;
   logic [7:0]        rd_char;
   logic [7:0]        wait_ticks_ff;

   assign req_if.ready = !out_valid_ff || rsp_if.ready;
   assign accept       = req_if.valid && req_if.ready;

   clrs_seq #(.ROW_LENGTH(ROW_LENGTH)) u_seq (
      .clock          (clock),
      .reset          (reset),
      .accept         (accept),
      .command        (req_if.command),
      .cell_index     (req_if.cell_index),
      .char_value     (req_if.char_value),
      .cursor_position(req_if.cursor_position),
      .wait_ticks     (wait_ticks_ff),
      .emit           (emit),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .wr_en          (wr_en),
      .wr_addr        (wr_addr),
      .wr_data        (wr_data)
   );

   clrs_buf #(.ROW_LENGTH(ROW_LENGTH)) u_buf (
      .clock  (clock),
      .reset  (reset),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_char(rd_char)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         wait_ticks_ff <= WAIT_RESET;
      end else begin
         if (accept) begin
            out_valid_ff <= emit.emit;
         end else if (rsp_if.ready) begin
            out_valid_ff <= 1'b0;
         end
         if (psel && penable && pwrite && paddr == CSR_WAIT_TICKS) begin
            wait_ticks_ff <= pwdata[7:0];
         end
      end
      if (accept && emit.emit) begin
         out_ff <= emit;
      end
   end

   assign rsp_if.valid           = out_valid_ff;
   assign rsp_if.register_select = out_ff.register_select;
   assign rsp_if.data_byte       = out_ff.from_mem ? rd_char : out_ff.data_byte;

   assign pready = 1'b1;
   assign prdata = (paddr == CSR_WAIT_TICKS) ? {24'd0, wait_ticks_ff} : 32'd0;

endmodule

FILE: rtl/clrs_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module clrs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/clrs_buf.sv
// Character buffer: RAM plus per-cell written flags so unwritten cells read blank.
// Depends on clrs_pkg and clrs_ram.
module clrs_buf import clrs_pkg::*; #(
   parameter int ROW_LENGTH = 16,
   localparam int CELL_COUNT = 2 * ROW_LENGTH,
   localparam int ADDR_W = $clog2(CELL_COUNT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [7:0]        wr_data,
   output logic [7:0]        rd_char
);

   logic [CELL_COUNT-1:0] valid_ff;
   logic [CELL_COUNT-1:0] valid_in;
   logic                  rd_valid_ff;
   logic [7:0]            ram_q;

   clrs_ram #(.WIDTH(8), .DEPTH(CELL_COUNT)) u_ram (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(ram_q)
   );

   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_char = rd_valid_ff ? ram_q : BLANK_CODE;

endmodule

FILE: rtl/clrs_seq.sv
// Refresh sequencer control: cell counter, row tracking, wait counter, cursor.
// Decides each request's emission and the buffer access. Depends on clrs_pkg.
module clrs_seq import clrs_pkg::*; #(
   parameter int ROW_LENGTH = 16,
   localparam int CELL_COUNT = 2 * ROW_LENGTH,
   localparam int CELL_W = $clog2(CELL_COUNT + 1),
   localparam int ADDR_W = $clog2(CELL_COUNT)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [1:0]        command,
   input  logic [4:0]        cell_index,
   input  logic [7:0]        char_value,
   input  logic [4:0]        cursor_position,
   input  logic [7:0]        wait_ticks,
   output emit_type          emit,
   output logic              rd_en,
   output logic [ADDR_W-1:0] rd_addr,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [7:0]        wr_data
);

   typedef enum logic [1:0] {
      ROW_TOP     = 2'd0,
      ROW_BOTTOM  = 2'd1,
      ROW_UNKNOWN = 2'd2
   } row_type;

   logic [CELL_W-1:0] next_cell_ff, next_cell_in;
   row_type           row_ff, row_in;
   logic              waiting_ff, waiting_in;
   logic [7:0]        idle_ff, idle_in;
   logic [4:0]        cursor_ff, cursor_in;
   cmd_type           cmd;
   logic              in_range;
   logic [7:0]        cursor_byte;

   assign cmd      = cmd_type'(command);
   assign in_range = int'(cell_index) < CELL_COUNT;
   assign rd_addr  = next_cell_ff[ADDR_W-1:0];
   assign wr_addr  = ADDR_W'(cell_index);
   assign wr_data  = (cmd == CMD_WRITE_DIGIT) ? digit_code(char_value) : char_value;

   always_comb begin
      if (int'(cursor_ff) < ROW_LENGTH) begin
         cursor_byte = 8'(int'(cursor_ff) + int'(ROW0_ADDR));
      end else begin
         cursor_byte = 8'(int'(cursor_ff) + int'(ROW1_ADDR) - ROW_LENGTH);
      end
   end

   always_comb begin
      next_cell_in = next_cell_ff;
      row_in       = row_ff;
      waiting_in   = waiting_ff;
      idle_in      = idle_ff;
      cursor_in    = cursor_ff;
      emit         = '0;
      rd_en        = 1'b0;
      wr_en        = 1'b0;
      if (accept) begin
         unique case (cmd)
            CMD_TICK: begin
               if (!waiting_ff) begin
                  emit.emit = 1'b1;
                  if (next_cell_ff < CELL_W'(CELL_COUNT)) begin
                     if (next_cell_ff == '0 && row_ff != ROW_TOP) begin
                        emit.data_byte = ROW0_ADDR;
                        row_in         = ROW_TOP;
                     end else if (next_cell_ff == CELL_W'(ROW_LENGTH)
                                  && row_ff != ROW_BOTTOM) begin
                        emit.data_byte = ROW1_ADDR;
                        row_in         = ROW_BOTTOM;
                     end else begin
                        emit.register_select = 1'b1;
                        emit.from_mem        = 1'b1;
                        rd_en                = 1'b1;
                        next_cell_in         = next_cell_ff + CELL_W'(1);
                     end
                  end else begin
                     emit.data_byte = cursor_byte;
                     next_cell_in   = '0;
                     waiting_in     = 1'b1;
                  end
               end else if (idle_ff < wait_ticks) begin
                  idle_in = idle_ff + 8'd1;
               end else begin
                  waiting_in = 1'b0;
                  idle_in    = '0;
               end
            end
            CMD_WRITE_RAW, CMD_WRITE_DIGIT: begin
               wr_en = in_range;
            end
            CMD_SET_CURSOR: begin
               cursor_in = cursor_position;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_cell_ff <= '0;
         row_ff       <= ROW_UNKNOWN;
         waiting_ff   <= 1'b0;
         idle_ff      <= '0;
         cursor_ff    <= '0;
      end else begin
         next_cell_ff <= next_cell_in;
         row_ff       <= row_in;
         waiting_ff   <= waiting_in;
         idle_ff      <= idle_in;
         cursor_ff    <= cursor_in;
      end
   end

endmodule

FILE: rtl/clrs_checker.sv
// Port-level checker for the refresh sequencer, bound to the top level.
// Depends on clrs_pkg and char_lcd_refresh_sequencer.
module clrs_checker import clrs_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [1:0] req_command,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_register_select,
   input logic [7:0] rsp_data_byte
);

   logic seen_rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_rsp_ff <= 1'b0;
      end else if (rsp_valid) begin
         seen_rsp_ff <= 1'b1;
      end
   end

   a_first_is_row0 : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !seen_rsp_ff) |-> (!rsp_register_select && rsp_data_byte == ROW0_ADDR))
      else $error("first response is not the top row address");

   a_instr_has_msb : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_register_select) |-> rsp_data_byte[7])
      else $error("instruction byte without address bit");

   a_rsp_from_tick : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready && req_command == CMD_TICK))
      else $error("response without an accepted tick");

   a_ready_when_empty : assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request stalled with empty output");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data_byte)))
      else $error("stalled response dropped or changed");

endmodule

bind char_lcd_refresh_sequencer clrs_checker u_clrs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .req_command        (req_if.command),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_register_select(rsp_if.register_select),
   .rsp_data_byte      (rsp_if.data_byte)
);
